[sv/wti_pkg.sv]
// ----------------------------------------------------------------------------
// wti_pkg
// Shared types and constants for the waveform table interpolator.
// ----------------------------------------------------------------------------
package wti_pkg;

  localparam int unsigned NUM_CH     = 16;
  localparam int unsigned NUM_SMP    = 256;
  localparam int unsigned CH_W       = 4;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned CNT_W      = 9;
  localparam int unsigned ADDR_W     = CH_W + IDX_W;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned NCH_W      = 5;

  // input actions
  localparam logic [1:0] ACT_WRITE   = 2'd0;
  localparam logic [1:0] ACT_COUNT   = 2'd1;
  localparam logic [1:0] ACT_TICK    = 2'd2;
  localparam logic [1:0] ACT_IGNORED = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_INTERP  = 2'd0;
  localparam logic [1:0] CFG_INTEGER = 2'd1;
  localparam logic [1:0] CFG_ACTIVE  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CH_START,
    ST_WALK,
    ST_POSTWALK,
    ST_HOLD_RD,
    ST_LIN_A,
    ST_LIN_B,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EMIT
  } wti_state_t;

  // divider handshake toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } wti_div_stat_t;

endpackage

[sv/waveform_table_interpolator.sv]
// ----------------------------------------------------------------------------
// waveform_table_interpolator
// Multi-channel breakpoint player with hold or linear interpolation.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | carries
//  in_     | input     | in_valid/in_ready  | load or tick word
//  out_    | output    | out_valid/out_ready| one channel value per word
//  cfg_    | input     | cfg_we             | mode, integer flag, channel count
//
//  A load word is taken in the idle state. A tick walks the active
//  channels one at a time: per channel it compares breakpoints, then an
//  empty channel emits zero, hold reads one breakpoint and interpolation
//  runs the bit-serial 64-bit divider.
//  The next word is taken once the last value of a tick sits in the output
//  register. Reset clears counts, positions and config, not the tables.
//  A stalled output holds the walk at the next channel's emit.
// ----------------------------------------------------------------------------
module waveform_table_interpolator (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_action,
  input  logic [wti_pkg::CH_W-1:0]     in_channel,
  input  logic [wti_pkg::IDX_W-1:0]    in_entry_index,
  input  logic signed [31:0]           in_entry_time,
  input  logic signed [31:0]           in_entry_value,
  input  logic [wti_pkg::CNT_W-1:0]    in_entry_count,
  input  logic signed [31:0]           in_now_time,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [wti_pkg::CH_W-1:0]     out_channel,
  output logic signed [31:0]           out_value,
  output logic                         out_last,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [wti_pkg::NCH_W-1:0]    cfg_wdata
);
  import wti_pkg::*;

  wti_state_t state_r, state_nxt;

  logic             interp_r, integer_r;
  logic [NCH_W-1:0] active_r;
  logic [CNT_W-1:0] counts_r [NUM_CH];
  logic [CNT_W-1:0] posns_r  [NUM_CH];

  logic [CH_W-1:0]   ch_r;
  logic [NCH_W-1:0]  n_r;
  logic [31:0]       now_r;
  logic [CNT_W-1:0]  cnt_r, pos_r;
  logic [31:0]       tp_r, vp_r;
  logic [31:0]       adt_r, adv_r, span_r;
  logic              neg_r;
  logic [63:0]       prod_r;
  logic [31:0]       result_r;

  logic              out_valid_r;
  logic [CH_W-1:0]   out_ch_r;
  logic [31:0]       out_val_r;
  logic              out_last_r;

  logic              accept, tick_acc, slot_free, is_last;
  logic [NCH_W-1:0]  n_sat;
  logic [CNT_W-1:0]  pos_start, pos_inc, hold_p;
  logic              advance, hold_path;
  logic [ADDR_W-1:0] rd_addr;
  logic [31:0]       rtime, rvalue;
  logic              div_start, emit_load;
  logic [63:0]       quotient;
  wti_div_stat_t     div_stat;

  logic signed [32:0] span_w, dt_w, dv_w;
  logic [31:0]        adt_w, adv_w;
  logic               span_bad;
  logic [33:0]        q_sat;
  logic signed [34:0] sum_w;
  logic [31:0]        lin_val;

  // handshake and common terms
  assign accept    = in_valid && in_ready;
  assign tick_acc  = accept && (in_action == ACT_TICK);
  assign n_sat     = (active_r > NCH_W'(NUM_CH)) ? NCH_W'(NUM_CH) : active_r;
  assign slot_free = !out_valid_r || out_ready;
  assign is_last   = ({1'b0, ch_r} + NCH_W'(1)) == n_r;

  // walk terms
  assign pos_start = (posns_r[ch_r] > counts_r[ch_r]) ? counts_r[ch_r] : posns_r[ch_r];
  assign pos_inc   = pos_r + CNT_W'(1);
  assign advance   = $signed(now_r) > $signed(rtime);
  assign hold_p    = (pos_r == cnt_r) ? pos_r - CNT_W'(1) : pos_r;
  assign hold_path = integer_r || !interp_r || (pos_r == '0) || (pos_r == cnt_r);

  // interpolation setup from neighbours
  always_comb begin
    span_w   = $signed({rtime[31], rtime}) - $signed({tp_r[31], tp_r});
    dt_w     = $signed({now_r[31], now_r}) - $signed({tp_r[31], tp_r});
    dv_w     = $signed({rvalue[31], rvalue}) - $signed({vp_r[31], vp_r});
    span_bad = span_w[32] || (span_w == '0);
    adt_w    = dt_w[32] ? 32'(-dt_w) : dt_w[31:0];
    adv_w    = dv_w[32] ? 32'(-dv_w) : dv_w[31:0];
  end

  // quotient saturation and clamp
  always_comb begin
    q_sat = (|quotient[63:33]) ? {1'b1, 33'd0} : quotient[33:0];
    if (neg_r) sum_w = $signed({{3{vp_r[31]}}, vp_r}) - $signed({1'b0, q_sat});
    else       sum_w = $signed({{3{vp_r[31]}}, vp_r}) + $signed({1'b0, q_sat});
    if (sum_w > 35'sh0_7FFF_FFFF)       lin_val = 32'h7FFF_FFFF;
    else if (sum_w < -35'sh0_8000_0000) lin_val = 32'h8000_0000;
    else                                lin_val = sum_w[31:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (tick_acc && (n_sat != '0)) state_nxt = ST_CH_START;
      ST_CH_START: state_nxt = (pos_start < counts_r[ch_r]) ? ST_WALK : ST_POSTWALK;
      ST_WALK:     state_nxt = (advance && (pos_inc < cnt_r)) ? ST_WALK : ST_POSTWALK;
      ST_POSTWALK: begin
        if (cnt_r == '0)    state_nxt = ST_EMIT;
        else if (hold_path) state_nxt = ST_HOLD_RD;
        else                state_nxt = ST_LIN_A;
      end
      ST_HOLD_RD:  state_nxt = ST_EMIT;
      ST_LIN_A:    state_nxt = ST_LIN_B;
      ST_LIN_B:    state_nxt = span_bad ? ST_EMIT : ST_MUL;
      ST_MUL:      state_nxt = ST_DIV_GO;
      ST_DIV_GO:   state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_stat.done) state_nxt = ST_EMIT;
      ST_EMIT:     if (slot_free) state_nxt = is_last ? ST_IDLE : ST_CH_START;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready  = 1'b0;
    rd_addr   = '0;
    div_start = 1'b0;
    emit_load = 1'b0;
    unique case (state_r)
      ST_IDLE:     in_ready = 1'b1;
      ST_CH_START: rd_addr = {ch_r, pos_start[IDX_W-1:0]};
      ST_WALK:     rd_addr = {ch_r, pos_inc[IDX_W-1:0]};
      ST_POSTWALK: begin
        if (hold_path) rd_addr = {ch_r, hold_p[IDX_W-1:0]};
        else           rd_addr = {ch_r, IDX_W'(pos_r - CNT_W'(1))};
      end
      ST_LIN_A:    rd_addr = {ch_r, pos_r[IDX_W-1:0]};
      ST_DIV_GO:   div_start = 1'b1;
      ST_EMIT:     emit_load = slot_free;
      default:     ;
    endcase
  end

  // breakpoint memories
  wti_table u_table (
    .clk    (clk),
    .we     (accept && (in_action == ACT_WRITE)),
    .waddr  ({in_channel, in_entry_index}),
    .wtime  (in_entry_time),
    .wvalue (in_entry_value),
    .raddr  (rd_addr),
    .rtime  (rtime),
    .rvalue (rvalue)
  );

  // interpolation divider
  wti_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (span_r),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // control state, config, per-channel counts and positions
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      interp_r    <= 1'b0;
      integer_r   <= 1'b0;
      active_r    <= NCH_W'(1);
      out_valid_r <= 1'b0;
      ch_r        <= '0;
      n_r         <= '0;
      for (int i = 0; i < NUM_CH; i++) begin
        counts_r[i] <= '0;
        posns_r[i]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_INTERP:  interp_r  <= cfg_wdata[0];
          CFG_INTEGER: integer_r <= cfg_wdata[0];
          CFG_ACTIVE:  active_r  <= cfg_wdata;
          default:     ;
        endcase
      end
      if (accept && (in_action == ACT_COUNT)) begin
        counts_r[in_channel] <= (in_entry_count > CNT_W'(NUM_SMP)) ?
                                CNT_W'(NUM_SMP) : in_entry_count;
        posns_r[in_channel]  <= '0;
      end
      if (tick_acc) begin
        ch_r <= '0;
        n_r  <= n_sat;
      end
      if (state_r == ST_POSTWALK) posns_r[ch_r] <= pos_r;
      if (emit_load) begin
        out_valid_r <= 1'b1;
        if (!is_last) ch_r <= ch_r + CH_W'(1);
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (tick_acc) now_r <= in_now_time;
    if (state_r == ST_CH_START) begin
      cnt_r <= counts_r[ch_r];
      pos_r <= pos_start;
    end
    if ((state_r == ST_WALK) && advance) pos_r <= pos_inc;
    if ((state_r == ST_POSTWALK) && (cnt_r == '0)) result_r <= '0;
    if (state_r == ST_HOLD_RD)
      result_r <= integer_r ? {{16{rvalue[15]}}, rvalue[15:0]} : rvalue;
    if (state_r == ST_LIN_A) begin
      tp_r <= rtime;
      vp_r <= rvalue;
    end
    if (state_r == ST_LIN_B) begin
      result_r <= vp_r;
      adt_r    <= adt_w;
      adv_r    <= adv_w;
      span_r   <= span_w[31:0];
      neg_r    <= dt_w[32] != dv_w[32];
    end
    if (state_r == ST_MUL) prod_r <= adt_r * adv_r;
    if ((state_r == ST_DIV_WAIT) && div_stat.done) result_r <= lin_val;
    if (emit_load) begin
      out_ch_r   <= ch_r;
      out_val_r  <= result_r;
      out_last_r <= is_last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_channel = out_ch_r;
  assign out_value   = out_val_r;
  assign out_last    = out_last_r;

endmodule

[sv/wti_table.sv]
// ----------------------------------------------------------------------------
// wti_table
// Breakpoint time and value memories, one write port, one registered read.
// ----------------------------------------------------------------------------
module wti_table (
  input  logic                            clk,
  input  logic                            we,
  input  logic [wti_pkg::ADDR_W-1:0]      waddr,
  input  logic [wti_pkg::DATA_W-1:0]      wtime,
  input  logic [wti_pkg::DATA_W-1:0]      wvalue,
  input  logic [wti_pkg::ADDR_W-1:0]      raddr,
  output logic [wti_pkg::DATA_W-1:0]      rtime,
  output logic [wti_pkg::DATA_W-1:0]      rvalue
);
  import wti_pkg::*;

  logic [DATA_W-1:0] time_mem  [NUM_CH*NUM_SMP];
  logic [DATA_W-1:0] value_mem [NUM_CH*NUM_SMP];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      time_mem[waddr]  <= wtime;
      value_mem[waddr] <= wvalue;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rtime  <= time_mem[raddr];
    rvalue <= value_mem[raddr];
  end

endmodule

[sv/wti_div.sv]
// ----------------------------------------------------------------------------
// wti_div
// Restoring unsigned divider, 64 by 32 bits, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wti_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [63:0]            dividend,
  input  logic [31:0]            divisor,
  output logic [63:0]            quotient,
  output wti_pkg::wti_div_stat_t stat
);
  import wti_pkg::*;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  step_r, step_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [32:0] trial;
  logic [32:0] diff;

  // one trial subtraction per cycle
  always_comb begin
    trial    = {rem_r, quo_r[63]};
    diff     = trial - {1'b0, divisor};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      if (!diff[32]) begin
        rem_nxt = diff[31:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      step_nxt = step_r + 6'd1;
      if (step_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

[sv/wti_checker.sv]
// ----------------------------------------------------------------------------
// wti_assert
// Port-level checks for the waveform table interpolator.
// ----------------------------------------------------------------------------
module wti_assert (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [wti_pkg::CH_W-1:0] out_channel,
  input logic [31:0]              out_value,
  input logic                     out_last
);
  import wti_pkg::*;

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) &&
    $stable(out_channel) && $stable(out_last))
    else $error("output word changed while stalled");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // no input taken while a tick still has channels to send
  a_tick_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input ready in the middle of a tick");

  // a non-final word never carries the highest channel number, so no wrap
  a_ch_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |-> out_channel != {CH_W{1'b1}})
    else $error("channel sequence runs past the last channel");

endmodule

bind waveform_table_interpolator wti_assert u_wti_assert (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_channel (out_channel),
  .out_value   (out_value),
  .out_last    (out_last)
);

[sim/wti_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wti_checker
// Watches the load/tick and value channels of the waveform table
// interpolator, keeps its own copy of tables, counts, read positions and
// configuration, predicts every value word of a tick and compares each
// accepted output word with the oldest prediction.
// ----------------------------------------------------------------------------
module wti_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [1:0]                in_action,
  input  logic [wti_pkg::CH_W-1:0]  in_channel,
  input  logic [wti_pkg::IDX_W-1:0] in_entry_index,
  input  logic signed [31:0]        in_entry_time,
  input  logic signed [31:0]        in_entry_value,
  input  logic [wti_pkg::CNT_W-1:0] in_entry_count,
  input  logic signed [31:0]        in_now_time,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [wti_pkg::CH_W-1:0]  out_channel,
  input  logic signed [31:0]        out_value,
  input  logic                      out_last,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [wti_pkg::NCH_W-1:0] cfg_wdata,
  output int                        fail_count,
  output int                        pending
);
  import wti_pkg::*;

  typedef struct {
    logic [CH_W-1:0]    chan;
    logic signed [31:0] value;
    logic               last;
  } chan_value_t;

  chan_value_t        value_q[$];

  logic               mode_linear;
  logic               mode_int16;
  logic [NCH_W-1:0]   num_active;
  logic signed [31:0] bp_time [NUM_CH][NUM_SMP];
  logic signed [31:0] bp_value[NUM_CH][NUM_SMP];
  logic [CNT_W-1:0]   bp_count[NUM_CH];
  logic [CNT_W-1:0]   rd_pos  [NUM_CH];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // exact linear blend, truncating division, saturated to 32 bits
  function automatic longint blend(longint now, longint tp, longint tn,
                                   longint vp, longint vn);
    longint          span, dt, dv, r;
    longint unsigned adt, adv, ud, hi, lo, q;
    logic            neg;
    span = tn - tp;
    dt   = now - tp;
    dv   = vn - vp;
    if (span <= 0) return vp;
    adt = (dt < 0) ? longint'(-dt) : dt;
    adv = (dv < 0) ? longint'(-dv) : dv;
    neg = (dt < 0) != (dv < 0);
    ud  = span;
    hi  = adv / ud;
    lo  = adv % ud;
    if (hi != 0 && adt > (64'd1 << 36) / hi)
      return neg ? -64'sd2147483648 : 64'sd2147483647;
    q = hi * adt + (lo * adt) / ud;
    r = neg ? vp - longint'(q) : vp + longint'(q);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r;
  endfunction

  // walk every active channel for one tick and queue its value words
  task automatic predict_tick(input logic signed [31:0] now);
    int          n, ch, c, p, q;
    longint      v;
    chan_value_t w;
    n = num_active;
    if (n > NUM_CH) n = NUM_CH;
    for (ch = 0; ch < n; ch++) begin
      c = bp_count[ch];
      p = rd_pos[ch];
      if (c > NUM_SMP) c = NUM_SMP;
      if (p > c) p = c;
      while (p < c && now > bp_time[ch][p]) p++;
      rd_pos[ch] = CNT_W'(p);
      q = (p == c) ? p - 1 : p;
      if (c == 0) begin
        v = 0;
      end else if (mode_int16) begin
        v = longint'($signed(bp_value[ch][q][15:0]));
      end else if (!mode_linear || p == 0 || p == c) begin
        v = bp_value[ch][q];
      end else begin
        v = blend(now, bp_time[ch][p-1], bp_time[ch][p],
                  bp_value[ch][p-1], bp_value[ch][p]);
      end
      w.chan  = CH_W'(ch);
      w.value = v[31:0];
      w.last  = (ch + 1 == n);
      value_q = {value_q, w};
    end
  endtask

  always @(posedge clk) begin
    chan_value_t e;
    if (!rst_n) begin
      mode_linear = 1'b0;
      mode_int16  = 1'b0;
      num_active  = 1;
      for (int i = 0; i < NUM_CH; i++) begin
        bp_count[i] = '0;
        rd_pos[i]   = '0;
      end
      value_q.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_INTERP:  mode_linear = cfg_wdata[0];
          CFG_INTEGER: mode_int16  = cfg_wdata[0];
          CFG_ACTIVE:  num_active  = cfg_wdata;
          default: ;
        endcase
      end
      // accepted load or tick word
      if (in_valid && in_ready) begin
        case (in_action)
          ACT_WRITE: begin
            bp_time[in_channel][in_entry_index]  = in_entry_time;
            bp_value[in_channel][in_entry_index] = in_entry_value;
          end
          ACT_COUNT: begin
            bp_count[in_channel] = (in_entry_count > CNT_W'(NUM_SMP)) ?
                                   CNT_W'(NUM_SMP) : in_entry_count;
            rd_pos[in_channel]   = '0;
          end
          ACT_TICK: predict_tick(in_now_time);
          default: ;
        endcase
      end
      // accepted value word
      if (out_valid && out_ready) begin
        if (value_q.size() == 0) begin
          $error("value word with none predicted: channel %0d value %0d",
                 out_channel, out_value);
          fail_count++;
        end else begin
          e = value_q.pop_front();
          if (out_channel !== e.chan) begin
            $error("out_channel expected %0d actual %0d", e.chan, out_channel);
            fail_count++;
          end
          if (out_value !== e.value) begin
            $error("out_value expected %0d actual %0d", e.value, out_value);
            fail_count++;
          end
          if (out_last !== e.last) begin
            $error("out_last expected %0d actual %0d", e.last, out_last);
            fail_count++;
          end
        end
      end
    end
    pending <= value_q.size();
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives load and tick words into the waveform table interpolator with
// bursty input and a stalling output, across hold, linear and integer
// settings; the checker beside the block predicts and compares every value.
// ----------------------------------------------------------------------------
module testbench;
  import wti_pkg::*;

  localparam int CYCLE_LIMIT = 10000000;
  localparam int RANDOM_ITEMS = 420;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_action = ACT_WRITE;
  logic [CH_W-1:0]    in_channel = '0;
  logic [IDX_W-1:0]   in_entry_index = '0;
  logic signed [31:0] in_entry_time = '0;
  logic signed [31:0] in_entry_value = '0;
  logic [CNT_W-1:0]   in_entry_count = '0;
  logic signed [31:0] in_now_time = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [CH_W-1:0]    out_channel;
  logic signed [31:0] out_value;
  logic               out_last;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = CFG_INTERP;
  logic [NCH_W-1:0]   cfg_wdata = '0;
  int                 fail_count;
  int                 pending;

  int                 words_sent = 0;
  int                 burst_left = 0;
  int                 cycles = 0;
  logic               long_hold_req = 1'b0;
  logic               long_done = 1'b0;
  int                 table_len[NUM_CH];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  waveform_table_interpolator uut (.*);

  wti_checker checker_i (.*);

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // output stall pattern, plus one long hold-off on request
  always @(posedge clk) begin
    static int hold_left = 0;
    static int seg_left = 0;
    static int seg_mode = 0;
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(10, 80);
        seg_mode = $urandom_range(0, 2);
      end
      seg_left--;
      case (seg_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 1);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // offer one word and wait for it to be taken; bursts with random gaps
  task automatic send_word(input logic [1:0] act, input int ch, input int idx,
                           input logic signed [31:0] t, input logic signed [31:0] v,
                           input int cnt, input logic signed [31:0] now);
    int gap;
    in_valid       <= 1'b1;
    in_action      <= act;
    in_channel     <= CH_W'(ch);
    in_entry_index <= IDX_W'(idx);
    in_entry_time  <= t;
    in_entry_value <= v;
    in_entry_count <= CNT_W'(cnt);
    in_now_time    <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 30);
      gap = $urandom_range(1, 20);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic put_entry(input int ch, input int idx, input logic signed [31:0] t,
                           input logic signed [31:0] v);
    send_word(ACT_WRITE, ch, idx, t, v, $urandom, $urandom);
    if (idx >= table_len[ch]) table_len[ch] = idx + 1;
  endtask

  task automatic put_count(input int ch, input int cnt);
    send_word(ACT_COUNT, ch, $urandom, $urandom, $urandom, cnt, $urandom);
  endtask

  task automatic put_tick(input logic signed [31:0] now);
    send_word(ACT_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, now);
  endtask

  // drain everything in flight before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_config(input logic m, input logic i, input int a);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_INTERP;
    cfg_wdata <= NCH_W'(m);
    @(posedge clk);
    cfg_index <= CFG_INTEGER;
    cfg_wdata <= NCH_W'(i);
    @(posedge clk);
    cfg_index <= CFG_ACTIVE;
    cfg_wdata <= NCH_W'(a);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [31:0] clip32(input longint x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  initial begin
    int     nch, k, cmax, m, na;
    longint t, step, lo, hi;
    for (int i = 0; i < NUM_CH; i++) table_len[i] = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes on channel 0, hold mode, one channel
    set_config(1'b0, 1'b0, 1);
    put_entry(0, 0, 32'sh80000000, 32'sh7fffffff);
    put_entry(0, 1, 0, 32'sh80000000);
    put_entry(0, 2, 32'sh7fffffff, 32'sh0001_8000);
    put_count(0, 3);
    put_tick(32'sh80000000);
    put_tick(-100);
    put_tick(5);
    put_tick(32'sh7fffffff);
    // unknown action is ignored
    send_word(ACT_IGNORED, 0, 0, 0, 0, 0, 0);
    put_tick(32'sh7fffffff);

    // linear, active count beyond the channel range, empty channels
    settle();
    set_config(1'b1, 1'b0, 31);
    put_count(0, 3);
    put_tick(32'sh80000000);
    put_tick(-1000);
    put_tick(-1);
    put_tick(1000000);
    put_tick(32'sh7fffffff);

    // integer samples, no active channel, then two channels
    settle();
    set_config(1'b1, 1'b1, 0);
    put_tick(0);
    settle();
    set_config(1'b0, 1'b1, 2);
    put_count(0, 3);
    put_entry(1, 0, 7, 32'sh1234_ffff);
    put_count(1, 1);
    put_tick(-5);
    put_tick(8);
    put_tick(32'sh7fffffff);

    // full table on channel 15, count saturating past the table size
    settle();
    set_config(1'b1, 1'b0, 16);
    for (int i = 0; i < NUM_SMP; i++)
      put_entry(15, i, clip32(-64'sd2147483648 + longint'(i) * 16777215), $urandom);
    put_count(15, 511);
    for (int j = 0; j < 6; j++)
      put_tick(clip32(-64'sd2147483648 + longint'(j) * 800000000 + $urandom_range(0, 9999)));

    // random phases of well-formed load/tick sequences with noise
    while (words_sent < RANDOM_ITEMS) begin
      settle();
      case ($urandom_range(0, 7))
        0: k = 16;
        1: k = 31;
        2: k = 0;
        default: k = $urandom_range(1, 6);
      endcase
      na = k;
      set_config($urandom_range(0, 1), ($urandom_range(0, 3) == 0), k);
      nch = (k == 0) ? 1 : ((k > NUM_CH) ? NUM_CH : k);
      lo = 64'sd2147483647;
      hi = -64'sd2147483648;
      for (int ch = 0; ch < nch; ch++) begin
        if (ch == 15 && $urandom_range(0, 1)) continue;
        k = $urandom_range(0, 6);
        if ($urandom_range(0, 5) == 0)
          t = $signed($urandom);
        else
          t = $signed($urandom_range(0, 200000)) - 100000;
        for (int i = 0; i < k; i++) begin
          put_entry(ch, i, clip32(t), $urandom);
          if (t < lo) lo = t;
          if (t > hi) hi = t;
          step = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 5000);
          if ($urandom_range(0, 20) == 0) step = $urandom;
          t = t + step;
        end
        put_count(ch, k);
      end
      if (lo > hi) begin
        lo = -1000;
        hi = 1000;
      end
      // the one long output hold-off while ticks keep coming
      if (!long_done && na != 0) begin
        long_done = 1'b1;
        long_hold_req = 1'b1;
        burst_left = 40;
      end
      m = $urandom_range(3, 9);
      for (int j = 0; j <= m; j++) begin
        if ($urandom_range(0, 7) == 0)
          put_tick($urandom);
        else
          put_tick(clip32(lo - 200 + (hi - lo + 400) * j / m));
        // noise: ignored action or a rewind of some channel
        if ($urandom_range(0, 9) == 0) begin
          if ($urandom_range(0, 1)) begin
            send_word(ACT_IGNORED, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom);
          end else begin
            k = $urandom_range(0, NUM_CH - 1);
            cmax = (table_len[k] == NUM_SMP) ? 511 : table_len[k];
            put_count(k, $urandom_range(0, cmax));
          end
        end
      end
    end

    // drain and verdict
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule
